// File: rtl/gne_pkg.sv
// Shared constants, types and helper functions of the grid neighbour expander.
`default_nettype none

package gne_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;

  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [COORD_W-1:0] coord_t;

  localparam dim_t COST_STRAIGHT = 9'd256;
  localparam dim_t COST_DIAGONAL = 9'd362;
  localparam dim_t DIM_RESET     = 9'd256;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_EXPAND = 1'b1;

  typedef enum logic [1:0] {
    OFF_NEG  = 2'd0,
    OFF_ZERO = 2'd1,
    OFF_POS  = 2'd2
  } off_e;

  typedef struct packed {
    dim_t w;
    dim_t h;
  } dims_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic          wdata;
  } mem_req_t;

  // x offset of neighbour k, scanned x-major
  function automatic off_e nbr_dx(logic [2:0] k);
    off_e r;
    case (k)
      3'd0, 3'd1, 3'd2: r = OFF_NEG;
      3'd3, 3'd4:       r = OFF_ZERO;
      default:          r = OFF_POS;
    endcase
    return r;
  endfunction

  function automatic off_e nbr_dy(logic [2:0] k);
    off_e r;
    case (k)
      3'd0, 3'd3, 3'd5: r = OFF_NEG;
      3'd1, 3'd6:       r = OFF_ZERO;
      default:          r = OFF_POS;
    endcase
    return r;
  endfunction

  function automatic logic [AW-1:0] grid_addr(dim_t x, dim_t y);
    logic [XW-1:0] xs;
    logic [YW-1:0] ys;
    xs = XW'(x);
    ys = YW'(y);
    return {xs, ys};
  endfunction

  function automatic dim_t abs_diff(dim_t a, dim_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// File: rtl/grid_neighbor_expander.sv
// Write item: stored in the grid memory at the edge that accepts it; it gives no result.
// Expand item: the sequencer reads the grid memory once per neighbour, for all eight, then
// checks the last read, then loads the final result into the output register and returns
// to idle for the next acceptance; a stalled output can hold these steps back.
// Reset: grid_width and grid_height return to 256; input ready stays low while all
// 65536 cells of the grid memory are swept to blocked.
`default_nettype none

module grid_neighbor_expander
  import gne_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire        action_i,
  input  wire  [7:0] cell_x_i,
  input  wire  [7:0] cell_y_i,
  input  wire        cell_free_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] neighbor_x_o,
  output logic [7:0] neighbor_y_o,
  output logic [8:0] step_cost_o,
  output logic [8:0] heuristic_o,
  output logic       found_o,
  output logic       last_o,
  input  wire        cfg_we_i,
  input  wire        cfg_index_i,
  input  wire  [8:0] cfg_wdata_i
);

  dim_t     grid_width_q, grid_height_q;
  dims_t    dims;
  mem_req_t mem_req;
  logic     mem_rdata;
  logic     mem_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DIM_RESET;
      grid_height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // limit the dimensions in use to the stored grid
  always_comb begin
    dims.w = (int'(grid_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : grid_width_q;
    dims.h = (int'(grid_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : grid_height_q;
  end

  gne_grid_mem u_grid_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  gne_expand u_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dims_i       (dims),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_free_i  (cell_free_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .neighbor_x_o (neighbor_x_o),
    .neighbor_y_o (neighbor_y_o),
    .step_cost_o  (step_cost_o),
    .heuristic_o  (heuristic_o),
    .found_o      (found_o),
    .last_o       (last_o),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .mem_busy_i   (mem_busy)
  );

endmodule

`default_nettype wire

// File: rtl/gne_grid_mem.sv
// Single-port occupancy grid memory with a clearing sweep after reset.
`default_nettype none

module gne_grid_mem
  import gne_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  mem_req_t req_i,
  output logic     rdata_o,
  output logic     busy_o
);

  logic          grid_mem [DEPTH];
  logic [AW-1:0] clr_addr_q;
  logic          busy_q;
  logic          rdata_q;
  logic [AW-1:0] addr;
  logic          we;
  logic          wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  // the sweep owns the port until every cell reads blocked
  always_comb begin
    addr  = busy_q ? clr_addr_q : req_i.addr;
    we    = busy_q | req_i.we;
    wdata = busy_q ? 1'b0 : req_i.wdata;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      grid_mem[addr] <= wdata;
    end
    rdata_q <= grid_mem[addr];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

// File: rtl/gne_expand.sv
// Expand sequencer: walks the eight neighbours and builds the result stream.
`default_nettype none

module gne_expand
  import gne_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  dims_t        dims_i,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire          action_i,
  input  wire  [7:0]   cell_x_i,
  input  wire  [7:0]   cell_y_i,
  input  wire          cell_free_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [7:0]   neighbor_x_o,
  output logic [7:0]   neighbor_y_o,
  output logic [8:0]   step_cost_o,
  output logic [8:0]   heuristic_o,
  output logic         found_o,
  output logic         last_o,
  output mem_req_t     mem_req_o,
  input  wire          mem_rdata_i,
  input  wire          mem_busy_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  typedef struct packed {
    logic   inb;
    coord_t nx;
    coord_t ny;
    dim_t   cost;
    dim_t   heur;
  } nbr_t;

  state_e        state_q, state_d;
  logic [3:0]    k_q;
  coord_t        cx_q, cy_q;
  logic          ev_valid_q;
  nbr_t          ev_q;
  logic [AW-1:0] ev_addr_q;
  logic          pend_valid_q;
  nbr_t          pend_q;
  logic          out_valid_q;
  coord_t        out_x_q, out_y_q;
  dim_t          out_cost_q, out_heur_q;
  logic          out_found_q, out_last_q;

  off_e          dx, dy;
  dim_t          cx9, cy9, nx, ny, wm1, hm1;
  logic          under_x, under_y;
  nbr_t          cand;
  logic [AW-1:0] cand_addr;
  logic [AW-1:0] wr_addr;
  logic          in_store;
  logic          accept;
  logic          out_free;
  logic          ev_found;
  logic          stall;
  logic          scan_go;
  logic          load_ev;
  logic          push_mid;
  logic          load_pend;
  logic          flush_go;

  // neighbour k: coordinates, bounds, cost and heuristic
  always_comb begin
    dx      = nbr_dx(k_q[2:0]);
    dy      = nbr_dy(k_q[2:0]);
    cx9     = {1'b0, cx_q};
    cy9     = {1'b0, cy_q};
    wm1     = dims_i.w - 9'd1;
    hm1     = dims_i.h - 9'd1;
    under_x = 1'b0;
    under_y = 1'b0;
    case (dx)
      OFF_NEG: begin
        under_x = (cx_q == '0);
        nx      = cx9 - 9'd1;
      end
      OFF_POS: nx = cx9 + 9'd1;
      default: nx = cx9;
    endcase
    case (dy)
      OFF_NEG: begin
        under_y = (cy_q == '0);
        ny      = cy9 - 9'd1;
      end
      OFF_POS: ny = cy9 + 9'd1;
      default: ny = cy9;
    endcase
    cand.inb  = !under_x && !under_y && (nx < dims_i.w) && (ny < dims_i.h);
    cand.nx   = nx[7:0];
    cand.ny   = ny[7:0];
    cand.cost = (dx != OFF_ZERO && dy != OFF_ZERO) ? COST_DIAGONAL : COST_STRAIGHT;
    cand.heur = DIM_W'({1'b0, abs_diff(nx, wm1)} + {1'b0, abs_diff(ny, hm1)});
    cand_addr = grid_addr(nx, ny);
  end

  assign in_ready_o = (state_q == ST_IDLE) && !mem_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_store   = (int'(cell_x_i) < MAX_WIDTH) && (int'(cell_y_i) < MAX_HEIGHT);
  assign wr_addr    = grid_addr({1'b0, cell_x_i}, {1'b0, cell_y_i});

  assign out_free  = !out_valid_q || out_ready_i;
  assign ev_found  = ev_valid_q && ev_q.inb && mem_rdata_i;
  // a held neighbour must leave through the output register before a new one
  assign stall     = ev_found && pend_valid_q && !out_free;
  assign scan_go   = (state_q == ST_SCAN) && !stall;
  assign load_ev   = scan_go && !k_q[3];
  assign load_pend = scan_go && ev_found;
  assign push_mid  = load_pend && pend_valid_q;
  assign flush_go  = (state_q == ST_FLUSH) && out_free;

  // re-read the held entry on a stall so its data is there again next cycle
  always_comb begin
    mem_req_o.we    = accept && (action_i == ACT_WRITE) && in_store;
    mem_req_o.wdata = cell_free_i;
    if (state_q == ST_SCAN) begin
      mem_req_o.addr = stall ? ev_addr_q : cand_addr;
    end else begin
      mem_req_o.addr = wr_addr;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && action_i == ACT_EXPAND) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_go && k_q[3]) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      ev_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && action_i == ACT_EXPAND) begin
        k_q        <= '0;
        ev_valid_q <= 1'b0;
      end else if (scan_go) begin
        ev_valid_q <= !k_q[3];
        if (load_ev) begin
          k_q <= k_q + 4'd1;
        end
      end
      if (load_pend) begin
        pend_valid_q <= 1'b1;
      end else if (flush_go) begin
        pend_valid_q <= 1'b0;
      end
      if (push_mid || flush_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= cell_x_i;
      cy_q <= cell_y_i;
    end
    if (load_ev) begin
      ev_q      <= cand;
      ev_addr_q <= cand_addr;
    end
    if (load_pend) begin
      pend_q <= ev_q;
    end
    if (push_mid) begin
      out_x_q     <= pend_q.nx;
      out_y_q     <= pend_q.ny;
      out_cost_q  <= pend_q.cost;
      out_heur_q  <= pend_q.heur;
      out_found_q <= 1'b1;
      out_last_q  <= 1'b0;
    end else if (flush_go) begin
      out_x_q     <= pend_valid_q ? pend_q.nx : '0;
      out_y_q     <= pend_valid_q ? pend_q.ny : '0;
      out_cost_q  <= pend_valid_q ? pend_q.cost : '0;
      out_heur_q  <= pend_valid_q ? pend_q.heur : '0;
      out_found_q <= pend_valid_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign neighbor_x_o = out_x_q;
  assign neighbor_y_o = out_y_q;
  assign step_cost_o  = out_cost_q;
  assign heuristic_o  = out_heur_q;
  assign found_o      = out_found_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

// File: rtl/gne_checker.sv
// Port-level checks of the grid neighbour expander and their binding.
`default_nettype none

module gne_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [7:0] neighbor_x_o,
  input wire [7:0] neighbor_y_o,
  input wire [8:0] step_cost_o,
  input wire [8:0] heuristic_o,
  input wire       found_o,
  input wire       last_o
);

  // a result waiting for the sink is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped before acceptance");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o)
    else $error("empty expand result not marked last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> neighbor_x_o == 8'd0 && neighbor_y_o == 8'd0 &&
                                step_cost_o == 9'd0 && heuristic_o == 9'd0)
    else $error("empty expand result carries a payload");

  a_cost_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> step_cost_o == 9'd256 || step_cost_o == 9'd362)
    else $error("step cost neither straight nor diagonal");

endmodule

bind grid_neighbor_expander gne_checker u_gne_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .neighbor_x_o (neighbor_x_o),
  .neighbor_y_o (neighbor_y_o),
  .step_cost_o  (step_cost_o),
  .heuristic_o  (heuristic_o),
  .found_o      (found_o),
  .last_o       (last_o)
);

`default_nettype wire

// File: tb/expand_checker.sv
// Checker for the grid neighbour expander: mirrors the grid and compares every result.
module expand_checker
  import gne_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  wire        action_i,
  input  wire  [7:0] cell_x_i,
  input  wire  [7:0] cell_y_i,
  input  wire        cell_free_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  wire  [7:0] neighbor_x_i,
  input  wire  [7:0] neighbor_y_i,
  input  wire  [8:0] step_cost_i,
  input  wire  [8:0] heuristic_i,
  input  wire        found_i,
  input  wire        last_i,
  input  wire        cfg_we_i,
  input  wire        cfg_index_i,
  input  wire  [8:0] cfg_wdata_i,
  output int         mismatches_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coord_t nx;
    coord_t ny;
    dim_t   cost;
    dim_t   heur;
    logic   found;
    logic   last;
  } nbr_result_t;

  bit [MAX_WIDTH*MAX_HEIGHT-1:0] free_map;
  dim_t                          cols_cfg;
  dim_t                          rows_cfg;
  nbr_result_t                   expected_nbrs[$];
  nbr_result_t                   got;
  nbr_result_t                   want;
  int                            mismatches;

  // Queue the free neighbours of one cell, x offset major, y offset minor.
  task automatic predict_expand(coord_t cx, coord_t cy);
    int          cols;
    int          rows;
    int          dx;
    int          dy;
    int          nx;
    int          ny;
    int          hits;
    nbr_result_t r;
    cols = (cols_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(cols_cfg);
    rows = (rows_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_cfg);
    hits = 0;
    for (dx = -1; dx <= 1; dx++) begin
      for (dy = -1; dy <= 1; dy++) begin
        nx = int'(cx) + dx;
        ny = int'(cy) + dy;
        if (dx == 0 && dy == 0) continue;
        if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
        if (!free_map[nx*MAX_HEIGHT + ny]) continue;
        r       = '0;
        r.nx    = coord_t'(nx);
        r.ny    = coord_t'(ny);
        r.cost  = (dx != 0 && dy != 0) ? COST_DIAGONAL : COST_STRAIGHT;
        r.heur  = dim_t'(((nx > cols - 1) ? nx - (cols - 1) : (cols - 1) - nx) +
                         ((ny > rows - 1) ? ny - (rows - 1) : (rows - 1) - ny));
        r.found = 1'b1;
        expected_nbrs.insert(expected_nbrs.size(), r);
        hits++;
      end
    end
    if (hits == 0) begin
      r      = '0;
      r.last = 1'b1;
      expected_nbrs.insert(expected_nbrs.size(), r);
    end else begin
      // mark the final neighbour of this expand
      r.last = 1'b1;
      expected_nbrs[expected_nbrs.size() - 1] = r;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map   = '0;
      cols_cfg   = DIM_RESET;
      rows_cfg   = DIM_RESET;
      mismatches = 0;
      expected_nbrs.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {neighbor_x_i, neighbor_y_i, step_cost_i, heuristic_i, found_i, last_i};
        if (expected_nbrs.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d cost=%0d h=%0d found=%b last=%b",
                   $time, got.nx, got.ny, got.cost, got.heur, got.found, got.last);
          mismatches++;
        end else begin
          want = expected_nbrs.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected x=%0d y=%0d cost=%0d h=%0d found=%b last=%b",
                     $time, want.nx, want.ny, want.cost, want.heur, want.found, want.last);
            $display("%0t:          actual   x=%0d y=%0d cost=%0d h=%0d found=%b last=%b",
                     $time, got.nx, got.ny, got.cost, got.heur, got.found, got.last);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_GRID_WIDTH) begin
          cols_cfg = cfg_wdata_i;
        end else if (cfg_index_i == CFG_GRID_HEIGHT) begin
          rows_cfg = cfg_wdata_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (action_i == ACT_WRITE) begin
          free_map[{cell_x_i, cell_y_i}] = cell_free_i;
        end else begin
          predict_expand(cell_x_i, cell_y_i);
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_nbrs.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the testbench: drives cell writes, expands and grid sizes, and reports the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gne_pkg::*;

  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int SETTLE_CYCLES   = 24;
  localparam int STALL_CYCLES    = 600;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 50;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic       action      = ACT_WRITE;
  logic [7:0] cell_x      = '0;
  logic [7:0] cell_y      = '0;
  logic       cell_free   = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] neighbor_x;
  logic [7:0] neighbor_y;
  logic [8:0] step_cost;
  logic [8:0] heuristic;
  logic       found;
  logic       last;
  logic       cfg_we      = 1'b0;
  logic       cfg_index   = CFG_GRID_WIDTH;
  logic [8:0] cfg_wdata   = '0;

  int mismatches;
  int pending;
  int items_sent    = 0;
  int results_taken = 0;
  int cycle_cnt     = 0;

  // grid sizes per phase: defaults first, then the extremes and a few in between
  dim_t phase_cols [NUM_PHASES] = '{9'd256, 9'd0, 9'd1, 9'd2, 9'd511, 9'd7, 9'd12, 9'd256, 9'd511};
  dim_t phase_rows [NUM_PHASES] = '{9'd256, 9'd3, 9'd1, 9'd511, 9'd5, 9'd0, 9'd9, 9'd256, 9'd511};

  grid_neighbor_expander DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .cell_x_i     (cell_x),
    .cell_y_i     (cell_y),
    .cell_free_i  (cell_free),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .neighbor_x_o (neighbor_x),
    .neighbor_y_o (neighbor_y),
    .step_cost_o  (step_cost),
    .heuristic_o  (heuristic),
    .found_o      (found),
    .last_o       (last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata)
  );

  expand_checker expand_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .cell_x_i     (cell_x),
    .cell_y_i     (cell_y),
    .cell_free_i  (cell_free),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .neighbor_x_i (neighbor_x),
    .neighbor_y_i (neighbor_y),
    .step_cost_i  (step_cost),
    .heuristic_i  (heuristic),
    .found_i      (found),
    .last_i       (last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      results_taken <= results_taken + 1;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // favour coordinates near the origin and near the edge in use
  function automatic coord_t pick_coord(dim_t lim);
    int span;
    int r;
    span = (lim > MAX_WIDTH) ? MAX_WIDTH : int'(lim);
    r    = $urandom_range(0, 9);
    if (r < 3) return coord_t'($urandom_range(0, 2));
    if (r < 7) return coord_t'($urandom_range(span >= 2 ? span - 2 : 0, span > 255 ? 255 : span));
    if (r < 9 && span > 0) return coord_t'($urandom_range(0, span - 1));
    return coord_t'($urandom_range(0, 255));
  endfunction

  task automatic send_item(logic act, coord_t x, coord_t y, logic fr);
    int gap;
    in_valid  <= 1'b1;
    action    <= act;
    cell_x    <= x;
    cell_y    <= y;
    cell_free <= fr;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drain every expected result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dims(dim_t cols, dim_t rows);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_wdata <= cols;
    @(posedge clk_i);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_wdata <= rows;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // free some neighbours of a cell, then expand it; now and then a stray transaction
  task automatic run_sequence(dim_t cols, dim_t rows);
    coord_t cx;
    coord_t cy;
    int     dx;
    int     dy;
    int     nx;
    int     ny;
    bit     fill_all;
    if ($urandom_range(0, 4) == 0) begin
      send_item(logic'($urandom_range(0, 1)), coord_t'($urandom_range(0, 255)),
                coord_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)));
      return;
    end
    cx       = pick_coord(cols);
    cy       = pick_coord(rows);
    fill_all = ($urandom_range(0, 4) == 0);
    for (dx = -1; dx <= 1; dx++) begin
      for (dy = -1; dy <= 1; dy++) begin
        nx = int'(cx) + dx;
        ny = int'(cy) + dy;
        if ((dx != 0 || dy != 0) && nx >= 0 && nx <= 255 && ny >= 0 && ny <= 255 &&
            (fill_all || $urandom_range(0, 2) == 0)) begin
          send_item(ACT_WRITE, coord_t'(nx), coord_t'(ny),
                    fill_all ? 1'b1 : logic'($urandom_range(0, 3) != 0));
        end
      end
    end
    send_item(ACT_EXPAND, cx, cy, logic'($urandom_range(0, 1)));
  endtask

  initial begin : receiver
    int hold;
    bit pressure_done;
    pressure_done = 1'b0;
    @(posedge clk_i);
    forever begin
      // hold off long enough for the block to back up into its input
      if (!pressure_done && results_taken >= 40) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
      end
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int p;
    int goal;
    int dx;
    int dy;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // whole grid blocked after reset: nothing to find at the origin
    send_item(ACT_EXPAND, 8'd0, 8'd0, 1'b0);
    send_item(ACT_WRITE, 8'd1, 8'd0, 1'b1);
    send_item(ACT_WRITE, 8'd0, 8'd1, 1'b1);
    send_item(ACT_WRITE, 8'd1, 8'd1, 1'b1);
    send_item(ACT_EXPAND, 8'd0, 8'd0, 1'b1);
    // block the diagonal again
    send_item(ACT_WRITE, 8'd1, 8'd1, 1'b0);
    send_item(ACT_EXPAND, 8'd0, 8'd0, 1'b0);
    // far corner, where the heuristic reaches zero
    send_item(ACT_WRITE, 8'd254, 8'd254, 1'b1);
    send_item(ACT_WRITE, 8'd255, 8'd254, 1'b1);
    send_item(ACT_WRITE, 8'd254, 8'd255, 1'b1);
    send_item(ACT_EXPAND, 8'd255, 8'd255, 1'b1);
    send_item(ACT_WRITE, 8'd255, 8'd255, 1'b1);
    send_item(ACT_EXPAND, 8'd254, 8'd254, 1'b0);
    // full ring of eight free neighbours
    for (dx = -1; dx <= 1; dx++) begin
      for (dy = -1; dy <= 1; dy++) begin
        if (dx != 0 || dy != 0) begin
          send_item(ACT_WRITE, coord_t'(128 + dx), coord_t'(127 + dy), 1'b1);
        end
      end
    end
    send_item(ACT_EXPAND, 8'd128, 8'd127, 1'b1);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        set_dims(phase_cols[p], phase_rows[p]);
      end
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        run_sequence(phase_cols[p], phase_rows[p]);
      end
    end

    settle();
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
